/* rtl/core/mhnt_pkg.sv */
// Package of the MIDI held note tracker: field widths, field types and status codes.
// It depends on nothing; the interfaces, the top level and the checker import it.
package mhnt_pkg;

	localparam int CHAN_W   = 4;
	localparam int STATUS_W = 8;
	localparam int DATA_W   = 7;

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [DATA_W-1:0]   data_t;

	localparam status_t STATUS_OFF_ALL = 8'h80;
	localparam status_t STATUS_CTRL    = 8'hB0;

endpackage

/* rtl/core/mhnt_if.sv */
// Valid/ready channel interfaces of the MIDI held note tracker, one for messages
// in and one for results out. They depend on mhnt_pkg.
interface mhnt_msg_if;
	import mhnt_pkg::*;

	logic    valid;
	logic    ready;
	chan_t   channel;
	status_t status;
	data_t   note;
	data_t   velocity;

	modport source (output valid, channel, status, note, velocity, input ready);
	modport sink (input valid, channel, status, note, velocity, output ready);
endinterface

interface mhnt_res_if;
	import mhnt_pkg::*;

	logic    valid;
	logic    ready;
	status_t status_byte;
	data_t   data_one;
	data_t   data_two;
	logic    last;
	logic    not_tracked;

	modport source (output valid, status_byte, data_one, data_two, last, not_tracked,
		input ready);
	modport sink (input valid, status_byte, data_one, data_two, last, not_tracked,
		output ready);
endinterface

/* rtl/core/midi_held_note_tracker_top.sv */
// Top level of the MIDI held note tracker: per-channel note lists in one memory.
// It depends on mhnt_pkg and the channel interfaces in mhnt_if.sv.
//
//   Channel  Direction  Payload                                           Accepted when
//   msg      sink       channel, status, note, velocity                   valid && ready
//   res      source     status_byte, data_one, data_two, last, not_tracked valid && ready
//
// A controller or untracked message goes on to the result register without a list scan.
// A tracked note scans its list one entry a cycle, then loads its result register.
// A channel-wide note off reads the note memory one entry a cycle while the sink takes
// every result and holds on a stall; for an empty list it gives no result at all.
// Reset empties every list at once; the result register lets a new message in while a
// result still waits.
module midi_held_note_tracker_top #(
	parameter int CHANNELS          = 16,
	parameter int NOTES_PER_CHANNEL = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mhnt_msg_if.sink   msg,
	mhnt_res_if.source res
);
	import mhnt_pkg::*;

	localparam int CNT_W  = $clog2(NOTES_PER_CHANNEL + 1);
	localparam int SLOTS  = CHANNELS * NOTES_PER_CHANNEL;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(NOTES_PER_CHANNEL);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_WALK = 4'b1000
	} state_t;

	state_t             state_q;
	chan_t              ch_q;
	status_t            status_q;
	data_t              note_q;
	data_t              vel_q;
	logic [CIDX_W-1:0]  cidx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   emit_idx_q;
	logic               found_q;
	logic               flag_q;
	logic               pend_s1;
	data_t              rdata_s1;
	logic [CNT_W-1:0]   count_q [CHANNELS];
	data_t              notes_mem [SLOTS];

	logic               res_v_q;
	status_t            res_sb_q;
	data_t              res_d1_q;
	data_t              res_d2_q;
	logic               res_last_q;
	logic               res_nt_q;

	logic               accept;
	logic               in_range;
	logic [CIDX_W-1:0]  in_cidx;
	logic [CNT_W-1:0]   in_cnt;
	logic               out_free;
	logic               hit;
	logic               scan_done;
	logic               do_write;
	logic               load_walk;
	logic               load_pass;
	logic               walk_last;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign in_range  = {1'b0, msg.channel} < (CHAN_W + 1)'(CHANNELS);
	assign in_cidx   = msg.channel[CIDX_W-1:0];
	assign in_cnt    = count_q[in_cidx];
	assign out_free  = !res_v_q || res.ready;

	assign hit       = pend_s1 && (rdata_s1 == note_q);
	assign scan_done = (state_q == ST_SCAN) && !pend_s1 && (rd_idx_q == cnt_q);
	assign do_write  = scan_done && !found_q && (cnt_q < FULL);
	assign load_walk = (state_q == ST_WALK) && pend_s1 && out_free;
	assign load_pass = (state_q == ST_EMIT) && out_free;
	assign walk_last = (emit_idx_q == cnt_q - CNT_W'(1));

	always_comb begin
		rd_en = 1'b0;
		unique case (state_q)
			ST_SCAN: rd_en = (rd_idx_q < cnt_q);
			ST_WALK: rd_en = (rd_idx_q < cnt_q) && (!pend_s1 || load_walk);
			default: rd_en = 1'b0;
		endcase
	end

	assign rd_addr = ADDR_W'(int'(cidx_q) * NOTES_PER_CHANNEL + int'(rd_idx_q));
	assign wr_addr = ADDR_W'(int'(cidx_q) * NOTES_PER_CHANNEL + int'(cnt_q));

	always_ff @(posedge clk) begin
		if (do_write) begin
			notes_mem[wr_addr] <= note_q;
		end
		if (rd_en) begin
			rdata_s1 <= notes_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_s1    <= 1'b0;
			rd_idx_q   <= '0;
			emit_idx_q <= '0;
			found_q    <= 1'b0;
			flag_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			pend_s1 <= rd_en || (pend_s1 && !load_walk && (state_q == ST_WALK));
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q   <= '0;
					emit_idx_q <= '0;
					found_q    <= 1'b0;
					flag_q     <= 1'b0;
					if (accept) begin
						if (msg.status == STATUS_OFF_ALL) begin
							if (in_range && (in_cnt != '0)) begin
								state_q <= ST_WALK;
							end
						end else if (in_range && (msg.status != STATUS_CTRL)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						flag_q  <= !found_q && (cnt_q == FULL);
						state_q <= ST_EMIT;
						if (do_write) begin
							count_q[cidx_q] <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (load_walk) begin
						emit_idx_q <= emit_idx_q + CNT_W'(1);
						if (walk_last) begin
							count_q[cidx_q] <= '0;
							state_q         <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= msg.channel;
			status_q <= msg.status;
			note_q   <= msg.note;
			vel_q    <= msg.velocity;
			cidx_q   <= in_cidx;
			cnt_q    <= in_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (load_walk || load_pass) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_walk) begin
			res_sb_q   <= STATUS_OFF_ALL | {{(STATUS_W - CHAN_W){1'b0}}, ch_q};
			res_d1_q   <= rdata_s1;
			res_d2_q   <= '0;
			res_last_q <= walk_last;
			res_nt_q   <= 1'b0;
		end else if (load_pass) begin
			res_sb_q   <= status_q + {{(STATUS_W - CHAN_W){1'b0}}, ch_q};
			res_d1_q   <= note_q;
			res_d2_q   <= vel_q;
			res_last_q <= 1'b1;
			res_nt_q   <= flag_q;
		end
	end

	assign res.valid       = res_v_q;
	assign res.status_byte = res_sb_q;
	assign res.data_one    = res_d1_q;
	assign res.data_two    = res_d2_q;
	assign res.last        = res_last_q;
	assign res.not_tracked = res_nt_q;

endmodule

/* rtl/core/mhnt_checker.sv */
// Port-level checker of the MIDI held note tracker and the bind that attaches it.
// It depends on mhnt_pkg and on the top level midi_held_note_tracker_top.
module mhnt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               msg_valid,
	input logic               msg_ready,
	input mhnt_pkg::status_t  msg_status,
	input logic               res_valid,
	input logic               res_ready,
	input mhnt_pkg::status_t  res_status_byte,
	input mhnt_pkg::data_t    res_data_one,
	input mhnt_pkg::data_t    res_data_two,
	input logic               res_last,
	input logic               res_not_tracked
);
	import mhnt_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status_byte)
			&& $stable(res_data_one) && $stable(res_data_two) && $stable(res_last))
		else $error("A stalled result item changed.");

	a_busy_after_msg: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && (msg_status != STATUS_OFF_ALL) |=> !msg_ready)
		else $error("A message item was followed by an immediate acceptance.");

	a_nonlast_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |->
			(res_status_byte[STATUS_W-1:CHAN_W] == STATUS_OFF_ALL[STATUS_W-1:CHAN_W])
			&& (res_data_two == '0) && !res_not_tracked)
		else $error("A result item that is not last is not a generated note off.");

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !msg_ready)
		else $error("A message item was accepted in the middle of a note off run.");

endmodule

bind midi_held_note_tracker_top mhnt_checker u_mhnt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.msg_valid       (msg.valid),
	.msg_ready       (msg.ready),
	.msg_status      (msg.status),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status_byte (res.status_byte),
	.res_data_one    (res.data_one),
	.res_data_two    (res.data_two),
	.res_last        (res.last),
	.res_not_tracked (res.not_tracked)
);
